[hdl/sha512_pkg.sv]
// SHA-512 package: command codes, round constants, sigma functions.
// No dependencies.
package sha512_pkg;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_FINAL = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic        init;
		logic        step;
		logic [6:0]  rnd;
	} rnd_ctl_t;

	localparam logic [63:0] IV_RESET [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

	function automatic logic [63:0] round_k(input logic [6:0] t);
		logic [63:0] k [80];
		k = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
		return (t < 7'd80) ? k[t] : 64'h0;
	endfunction

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic [63:0] bsig0(input logic [63:0] x);
		return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction
	function automatic logic [63:0] bsig1(input logic [63:0] x);
		return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction
	function automatic logic [63:0] ssig0(input logic [63:0] x);
		return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction
	function automatic logic [63:0] ssig1(input logic [63:0] x);
		return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

endpackage

[hdl/sha512_round.sv]
// SHA-512 round unit: working variables and 16-word schedule window.
// Depends on sha512_pkg.
module sha512_round (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha512_pkg::rnd_ctl_t  ctl,
	input  logic [63:0]           chain [8],
	input  logic                  win_wr,
	input  logic [3:0]            win_addr,
	input  logic [63:0]           win_data,
	output logic [63:0]           vars [8]
);
	import sha512_pkg::*;

	logic [63:0] v_q [8];
	logic [63:0] win_q [16];
	logic [3:0]  t4;
	logic [63:0] w, t1, t2;

	assign t4 = ctl.rnd[3:0];

	always_comb begin
		if (ctl.rnd < 7'd16) begin
			w = win_q[t4];
		end else begin
			w = ssig1(win_q[t4 - 4'd2]) + win_q[t4 - 4'd7]
				+ ssig0(win_q[t4 - 4'd15]) + win_q[t4];
		end
		t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ round_k(ctl.rnd) + w;
		t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) v_q[i] <= '0;
		end else if (ctl.init) begin
			for (int i = 0; i < 8; i++) v_q[i] <= chain[i];
		end else if (ctl.step) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk) begin
		if (win_wr) begin
			win_q[win_addr] <= win_data;
		end else if (ctl.step && ctl.rnd >= 7'd16) begin
			win_q[t4] <= w;
		end
	end

	assign vars = v_q;
endmodule

[hdl/sha2_512_hash_core.sv]
// SHA-512 hash core top level: command stream, APB IV registers, sequencer.
// Depends on sha512_pkg and sha512_round.
//
// Usage: after reset the IV registers hold the SHA-512 IV; rewrite them over
// APB (byte address 8*i, 64-bit data) only while the core is idle.
// Input stream: tdata = {valid_bytes[66:64], message_word[63:0]}, command in
// tuser. START loads the chaining words from the IV registers and clears the
// byte count. DATA stores one word; each sixteenth word starts a load of the
// working variables, 80 rounds at one round per cycle and an add of the result
// into the chaining words. FINAL pads the message by walking the 16 window
// slots per block, writing those past the stored message words, and runs one
// or two blocks, then emits eight digest words:
// tdata = digest_word, tuser = word_index, tlast = last_word. s_tready is low
// from the accepted item until its work and output are finished. The single
// round unit sets the rate. A stalled receiver holds the current word on the
// output; the core waits. Reset clears the sequencer, count and chaining words.
module sha2_512_hash_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,   // message_word[63:0], valid_bytes[66:64], zero
	input  logic [1:0]   s_tuser,   // command
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // digest_word[63:0]
	output logic [2:0]   m_tuser,   // word_index
	output logic         m_tlast,   // last_word
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);
	import sha512_pkg::*;

	state_t      state_q, state_d;
	logic [63:0] iv_q [8];
	logic [63:0] chain_q [8];
	logic [63:0] vars [8];
	logic [127:0] cnt_q;
	logic [3:0]  pos_q;
	logic [6:0]  rnd_q;
	logic        two_q;      // a second, length-only block follows
	logic [3:0]  pad_q;      // padding write pointer
	logic        padlen_q;   // padding the length block
	logic [2:0]  idx_q;
	logic [63:0] lastw_q;
	rnd_ctl_t    ctl;
	logic        win_wr;
	logic [3:0]  win_addr;
	logic [63:0] win_data;
	logic        acc;
	cmd_t        cmd;
	logic [63:0] keep;
	logic [127:0] cnt_fin;

	assign pready = 1'b1;
	assign prdata = iv_q[paddr[5:3]];
	assign acc = s_tvalid && s_tready;
	assign cmd = cmd_t'(s_tuser);

	always_comb begin
		keep = (s_tdata[66:64] == 3'd0) ? 64'h0 : ~64'h0 << (7'd64 - {s_tdata[66:64], 3'b000});
		cnt_fin = cnt_q + {125'h0, s_tdata[66:64]};
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && cmd == CMD_DATA && pos_q == 4'd15) state_d = ST_ROUND;
				else if (acc && cmd == CMD_FINAL) state_d = ST_PAD;
			end
			ST_PAD:   if (pad_q == 4'd15) state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 7'd80) state_d = ST_ADD;
			ST_ADD: begin
				if (two_q) state_d = ST_PAD;
				else if (padlen_q) state_d = ST_EMIT;
				else state_d = ST_IDLE;
			end
			ST_EMIT:  if (m_tready && idx_q == 3'd7) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = (state_q == ST_EMIT);
		m_tdata  = chain_q[idx_q];
		m_tuser  = idx_q;
		m_tlast  = (idx_q == 3'd7);
		ctl.init = (state_q == ST_ROUND) && rnd_q == 7'd0;
		ctl.step = (state_q == ST_ROUND) && rnd_q != 7'd0;
		ctl.rnd  = rnd_q - 7'd1;
		win_wr   = 1'b0;
		win_addr = pad_q;
		win_data = 64'h0;
		if (state_q == ST_IDLE && acc && cmd == CMD_DATA) begin
			win_wr = 1'b1; win_addr = pos_q; win_data = s_tdata[63:0];
		end else if (state_q == ST_PAD) begin
			win_wr = 1'b1;
			// length words only go in a block that ends the message
			if (pad_q == pos_q && !two_q) win_data = lastw_q;
			else if (pad_q == 4'd14 && !(two_q && !padlen_q)) win_data = {cnt_q[124:64], cnt_q[63:61]};
			else if (pad_q == 4'd15 && !(two_q && !padlen_q)) win_data = {cnt_q[60:0], 3'b000};
			else if (pad_q == pos_q && two_q && !padlen_q) win_data = lastw_q;
			else win_data = 64'h0;
			// hold the message words already in the window
			if (pad_q < pos_q) win_wr = 1'b0;
		end
	end

	sha512_round u_round (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .chain(chain_q),
		.win_wr(win_wr), .win_addr(win_addr), .win_data(win_data), .vars(vars));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < 8; i++) begin
				iv_q[i] <= IV_RESET[i];
				chain_q[i] <= '0;
			end
			cnt_q <= '0; pos_q <= '0; rnd_q <= '0; two_q <= 1'b0;
			pad_q <= '0; padlen_q <= 1'b0; idx_q <= '0; lastw_q <= '0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && pready) iv_q[paddr[5:3]] <= pwdata;
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						priority case (cmd)
							CMD_START: begin
								for (int i = 0; i < 8; i++) chain_q[i] <= iv_q[i];
								cnt_q <= '0; pos_q <= '0;
							end
							CMD_DATA: begin
								cnt_q <= cnt_q + 128'd8;
								pos_q <= pos_q + 4'd1;
								padlen_q <= 1'b0;
							end
							CMD_FINAL: begin
								cnt_q <= cnt_fin;
								lastw_q <= (s_tdata[63:0] & keep)
									| (64'h80 << (6'd56 - {s_tdata[66:64], 3'b000}));
								two_q <= (pos_q >= 4'd14);
								padlen_q <= (pos_q < 4'd14);
								pad_q <= '0;
							end
							default: ;
						endcase
					end
					rnd_q <= '0;
				end
				ST_PAD: begin
					pad_q <= pad_q + 4'd1;
					rnd_q <= '0;
				end
				ST_ROUND: rnd_q <= rnd_q + 7'd1;
				ST_ADD: begin
					for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + vars[i];
					rnd_q <= '0;
					if (two_q) begin
						// the length-only block carries no message word
						two_q <= 1'b0; padlen_q <= 1'b1; pad_q <= '0; pos_q <= '0;
						lastw_q <= '0;
					end else if (padlen_q) begin
						pos_q <= '0; idx_q <= '0;
					end
				end
				ST_EMIT: if (m_tready) idx_q <= idx_q + 3'd1;
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) m_tvalid |-> !s_tready)
		else $error("output while accepting input");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser)))
		else $error("digest word dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q <= 7'd80))
		else $error("round counter overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("core not idle after last digest word");
endmodule
